>>> sv/sobel_edge_magnitude_rgb_core_assert.svh
// ----------------------------------------------------------------------------
// sobel edge core assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SEM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SEM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SEM_ASSERT(lbl, clk, rst, prop, msg)
`define SEM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/sem_pkg.sv
// ----------------------------------------------------------------------------
// sobel edge magnitude package
// shared types and constants of the sobel edge core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sem_pkg;
  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int GRAD_W = 11;
  localparam int SQ_W   = 21;
  localparam int FW_W   = 11;
  localparam int FH_W   = 12;
  localparam int CFG_W  = 12;

  localparam logic [SQ_W-1:0] SAT_LIMIT = 21'd65280;
  localparam logic [CH_W-1:0] MAG_MAX   = 8'd255;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  typedef logic [PIX_W-1:0] pix_t;

  // win[col][row], col 0 left, row 0 top
  typedef struct packed {
    pix_t [2:0][2:0] win;
    logic            row_end;
    logic            frame_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;
endpackage

>>> sv/sem_ram.sv
// ----------------------------------------------------------------------------
// sem ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/sem_front.sv
// ----------------------------------------------------------------------------
// sem front
// accepts words, keeps line stores and window, queues neighborhood jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sem_front import sem_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  input  q_status_t        q_status,
  output logic             push,
  output job_t             push_job
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > FW_W) ? CW : FW_W;

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_READ  = 6'b000010,
    F_EMIT  = 6'b000100,
    F_DREAD = 6'b001000,
    F_DCAP  = 6'b010000,
    F_DPUSH = 6'b100000
  } fstate_t;

  fstate_t         state;
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [CW-1:0]   col;
  logic [FH_W-1:0] row;
  logic [CW-1:0]   drain;
  pix_t [1:0][2:0] win;
  pix_t [2:0][1:0] dcol;
  pix_t            px;
  pix_t            top;
  pix_t            mid;
  logic            sub;
  logic [1:0]      kk;

  logic [WW-1:0]   fw_ext;
  logic [CW-1:0]   eff_w;
  logic [FH_W-1:0] eff_h;
  logic [CW-1:0]   col_inc;
  logic [CW-1:0]   drain_inc;
  logic [CW:0]     didx;
  logic [CW:0]     didx_m1;
  logic            d_ok;
  logic            e1;
  logic            e2;
  logic            store_we;
  logic [AW-1:0]   raddr;
  pix_t            rd_above;
  pix_t            rd_two;

  assign fw_ext    = WW'(frame_width);
  assign eff_w     = (frame_width == '0) ? CW'(1) :
                     (fw_ext > WW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(fw_ext);
  assign eff_h     = (frame_height == '0) ? FH_W'(1) : frame_height;
  assign col_inc   = col + CW'(1);
  assign drain_inc = drain + CW'(1);
  assign didx      = {1'b0, drain} + (CW + 1)'(kk);
  assign didx_m1   = didx - (CW + 1)'(1);
  assign d_ok      = (didx != '0) && (didx_m1 < {1'b0, eff_w});
  assign e1        = (row != '0) && (col != '0);
  assign e2        = (row != '0) && (col_inc == eff_w);
  assign in_ready  = (state == F_IDLE);
  assign raddr     = (state == F_IDLE) ? col[AW-1:0] : didx_m1[AW-1:0];
  assign store_we  = (state == F_EMIT) && sub && (!e2 || !q_status.full);

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_above (
    .clk(clk), .we(store_we), .waddr(col[AW-1:0]), .wdata(px),
    .raddr(raddr), .rdata(rd_above)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_two_above (
    .clk(clk), .we(store_we), .waddr(col[AW-1:0]), .wdata(mid),
    .raddr(raddr), .rdata(rd_two)
  );

  always_comb begin
    push     = 1'b0;
    push_job = '0;
    if (state == F_EMIT && !q_status.full) begin
      push = sub ? e2 : e1;
    end
    if (state == F_DPUSH) begin
      push = !q_status.full;
    end
    unique case (state)
      F_DPUSH: begin
        for (int c = 0; c < 3; c++) begin
          push_job.win[c][0] = dcol[c][0];
          push_job.win[c][1] = dcol[c][1];
        end
        push_job.row_end   = (drain_inc == eff_w);
        push_job.frame_end = (drain_inc == eff_w);
      end
      default: begin
        if (!sub) begin
          push_job.win[0] = win[0];
          push_job.win[1] = win[1];
          push_job.win[2] = {px, mid, top};
        end else begin
          push_job.win[0] = win[1];
          push_job.win[1] = {px, mid, top};
          push_job.row_end = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      col          <= '0;
      row          <= '0;
      drain        <= '0;
      win          <= '0;
      sub          <= 1'b0;
      kk           <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default:          frame_height <= frame_height;
      endcase
      state <= F_IDLE;
      col   <= '0;
      row   <= '0;
      drain <= '0;
      win   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            if (!action) begin
              if (row < eff_h && col < eff_w) begin
                px <= {red, green, blue};
                if (col == '0) begin
                  win <= '0;
                end
                state <= F_READ;
              end
            end else if (row >= eff_h && drain < eff_w) begin
              kk    <= '0;
              state <= F_DREAD;
            end
          end
        end
        F_READ: begin
          top   <= (row >= FH_W'(2)) ? rd_two : '0;
          mid   <= (row != '0) ? rd_above : '0;
          sub   <= 1'b0;
          state <= F_EMIT;
        end
        F_EMIT: begin
          if (!sub) begin
            if (!e1 || !q_status.full) begin
              sub <= 1'b1;
            end
          end else if (!e2 || !q_status.full) begin
            win[0] <= win[1];
            win[1] <= {px, mid, top};
            if (col_inc >= eff_w) begin
              col <= '0;
              row <= row + FH_W'(1);
            end else begin
              col <= col_inc;
            end
            state <= F_IDLE;
          end
        end
        F_DREAD: state <= F_DCAP;
        F_DCAP: begin
          dcol[kk][0] <= d_ok ? rd_two : '0;
          dcol[kk][1] <= d_ok ? rd_above : '0;
          if (kk == 2'd2) begin
            state <= F_DPUSH;
          end else begin
            kk    <= kk + 2'd1;
            state <= F_DREAD;
          end
        end
        F_DPUSH: begin
          if (!q_status.full) begin
            if (drain_inc >= eff_w) begin
              col   <= '0;
              row   <= '0;
              drain <= '0;
              win   <= '0;
            end else begin
              drain <= drain_inc;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

>>> sv/sem_queue.sv
// ----------------------------------------------------------------------------
// sem queue
// two entry job queue between the front and the magnitude unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_rgb_core_assert.svh"
module sem_queue import sem_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      pop_job,
  output q_status_t status
);
  job_t       entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign pop_job      = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `SEM_ASSERT(a_no_overflow, clk, rst, !(push && status.full), "push into full queue")
  `SEM_ASSERT(a_no_underflow, clk, rst, !(pop && status.empty), "pop from empty queue")
  `SEM_ASSERT_NEXT(a_drain_empty, clk, rst, pop && !push && count == 2'd1, status.empty, "queue not empty after last pop")
  `SEM_ASSERT_NEXT(a_ptr_track, clk, rst, push && !pop && status.empty, wptr != rptr, "pointers out of step")
endmodule

>>> sv/sem_back.sv
// ----------------------------------------------------------------------------
// sem back
// gradient, square sum and serial rounded root for three channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sem_back import sem_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  q_status_t       q_status,
  output logic            pop,
  input  job_t            pop_job,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CH_W-1:0] edge_red,
  output logic [CH_W-1:0] edge_green,
  output logic [CH_W-1:0] edge_blue,
  output logic            row_end,
  output logic            frame_end
);
  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_GRAD = 6'b000010,
    B_SQ   = 6'b000100,
    B_ROOT = 6'b001000,
    B_RND  = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_t;

  bstate_t                  state;
  job_t                     job;
  logic signed [GRAD_W-1:0] gx [NUM_CH];
  logic signed [GRAD_W-1:0] gy [NUM_CH];
  logic signed [GRAD_W-1:0] gx_next [NUM_CH];
  logic signed [GRAD_W-1:0] gy_next [NUM_CH];
  logic [SQ_W-1:0]          s [NUM_CH];
  logic [SQ_W-1:0]          s_next [NUM_CH];
  logic [CH_W-1:0]          n [NUM_CH];
  logic [CH_W-1:0]          n_next [NUM_CH];
  logic [CH_W-1:0]          n_rnd [NUM_CH];
  logic [CH_W-1:0]          mask;
  logic                     load_out;

  assign pop      = (state == B_IDLE) && !q_status.empty;
  assign load_out = (state == B_OUT) && (!out_valid || out_ready);

  always_comb begin
    logic signed [GRAD_W-1:0] v [3][3];
    logic signed [21:0]       gx_sq;
    logic signed [21:0]       gy_sq;
    logic [CH_W-1:0]          t;
    logic [15:0]              tt;
    logic [16:0]              nn;
    for (int c = 0; c < NUM_CH; c++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          v[i][j] = $signed({3'b000, job.win[i][j][(2 - c) * CH_W +: CH_W]});
        end
      end
      gx_next[c] = (v[2][0] + GRAD_W'(2) * v[2][1] + v[2][2]) -
                   (v[0][0] + GRAD_W'(2) * v[0][1] + v[0][2]);
      gy_next[c] = (v[0][2] + GRAD_W'(2) * v[1][2] + v[2][2]) -
                   (v[0][0] + GRAD_W'(2) * v[1][0] + v[2][0]);
      gx_sq      = gx[c] * gx[c];
      gy_sq      = gy[c] * gy[c];
      s_next[c]  = gx_sq[SQ_W-1:0] + gy_sq[SQ_W-1:0];
      t          = n[c] | mask;
      tt         = t * t;
      n_next[c]  = ({5'b00000, tt} <= s[c]) ? t : n[c];
      nn         = n[c] * n[c] + n[c];
      if (s[c] > SAT_LIMIT) begin
        n_rnd[c] = MAG_MAX;
      end else if (s[c] > {4'b0000, nn}) begin
        n_rnd[c] = n[c] + CH_W'(1);
      end else begin
        n_rnd[c] = n[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_status.empty) begin
            job   <= pop_job;
            state <= B_GRAD;
          end
        end
        B_GRAD: begin
          gx    <= gx_next;
          gy    <= gy_next;
          state <= B_SQ;
        end
        B_SQ: begin
          s     <= s_next;
          for (int c = 0; c < NUM_CH; c++) begin
            n[c] <= '0;
          end
          mask  <= 8'h80;
          state <= B_ROOT;
        end
        B_ROOT: begin
          n    <= n_next;
          mask <= mask >> 1;
          if (mask == 8'h01) begin
            state <= B_RND;
          end
        end
        B_RND: begin
          n     <= n_rnd;
          state <= B_OUT;
        end
        B_OUT: begin
          if (load_out) begin
            edge_red   <= n[0];
            edge_green <= n[1];
            edge_blue  <= n[2];
            row_end    <= job.row_end;
            frame_end  <= job.frame_end;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

>>> sv/sobel_edge_magnitude_rgb_core.sv
// ----------------------------------------------------------------------------
// sobel edge magnitude rgb core
// 3x3 sobel gradient magnitude per color channel on a raster pixel stream.
// A pixel word passes the front as accept, line store read and two queue
// slots; a drain word as accept, three store reads (read, capture), push.
// The magnitude unit works on one job at a time: gradient, square sum,
// bit-serial root (one bit per step), rounding, output; a pixel at a row end
// yields two results. Results lag by one row and one column; after the last
// pixel, one drain word per result flushes the last row. The two line stores
// need no clearing pass and are written before they are read within a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb_core import sem_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CH_W-1:0]  edge_red,
  output logic [CH_W-1:0]  edge_green,
  output logic [CH_W-1:0]  edge_blue,
  output logic             row_end,
  output logic             frame_end
);
  q_status_t q_status;
  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      pop_job;

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .red(red), .green(green), .blue(blue),
    .q_status(q_status), .push(push), .push_job(push_job)
  );

  sem_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job),
    .pop(pop), .pop_job(pop_job), .status(q_status)
  );

  sem_back u_back (
    .clk(clk), .rst(rst), .q_status(q_status), .pop(pop), .pop_job(pop_job),
    .out_valid(out_valid), .out_ready(out_ready),
    .edge_red(edge_red), .edge_green(edge_green), .edge_blue(edge_blue),
    .row_end(row_end), .frame_end(frame_end)
  );
endmodule
